[rtl/core/isc_pkg.sv]
// Shared types and constants of the include directive scanner.
// No dependencies; isc_front, isc_queue, isc_back, the top level and the bench import it.
package isc_pkg;

	localparam int LEN_W = 7;

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [2:0] KW_TAIL_LEN = 3'd6;

	typedef enum logic [8:0] {
		M_IDLE    = 9'b000000001,
		M_HASH    = 9'b000000010,
		M_KEYWORD = 9'b000000100,
		M_OPENER  = 9'b000001000,
		M_NAME    = 9'b000010000,
		M_SLASH   = 9'b000100000,
		M_LINE    = 9'b001000000,
		M_BLOCK   = 9'b010000000,
		M_STAR    = 9'b100000000
	} scan_mode_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_buffer;
	} in_item_t;

	typedef struct packed {
		logic [7:0] name_byte;
		logic       name_empty;
		logic       name_last;
		logic       name_truncated;
	} out_item_t;

	// one finished name waiting in the buffer
	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic             ovf;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} job_push_t;

	// "nclude", the keyword after the leading 'i'
	function automatic logic [7:0] kw_char(input logic [2:0] pos);
		logic [7:0] ch;
		case (pos)
			3'd0:    ch = 8'h6E;
			3'd1:    ch = 8'h63;
			3'd2:    ch = 8'h6C;
			3'd3:    ch = 8'h75;
			3'd4:    ch = 8'h64;
			3'd5:    ch = 8'h65;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

[rtl/core/isc_chan_if.sv]
// Valid/ready channel with a typed payload.
// Payload types come from isc_pkg.
interface isc_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/isc_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module isc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[rtl/core/isc_front.sv]
// Front end: accepts source bytes, runs the scan state machine, fills the name RAM
// and pushes one job per closed name. Depends on isc_pkg and isc_chan_if.
module isc_front
	import isc_pkg::*;
#(
	parameter int NAME_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	isc_chan_if.sink                      bytes,
	input  logic                          queue_ready,
	input  logic                          back_busy,
	output job_push_t                     push,
	output logic                          ram_we,
	output logic [$clog2(NAME_DEPTH)-1:0] ram_waddr,
	output logic [7:0]                    ram_wdata
);
	localparam int AW = $clog2(NAME_DEPTH);

	scan_mode_t       mode_q, mode_d;
	logic [2:0]       pos_q, pos_d;
	logic             match_q, match_d;
	logic             quote_q, quote_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic             ovf_q, ovf_d;

	logic [7:0] c;
	logic       blank, eol, closer, accept, m, we;
	logic [2:0] p;

	assign c      = bytes.data.text_byte;
	assign blank  = (c == CH_SP) || (c == CH_TAB);
	assign eol    = (c == CH_LF) || (c == CH_CR);
	assign closer = (c == (quote_q ? CH_QUOTE : CH_GT));

	// the RAM belongs to the back end until its current name is out
	assign bytes.ready = queue_ready && !((mode_q == M_NAME) && back_busy);
	assign accept      = bytes.valid && bytes.ready;

	always_comb begin
		mode_d  = mode_q;
		pos_d   = pos_q;
		match_d = match_q;
		quote_d = quote_q;
		len_d   = len_q;
		ovf_d   = ovf_q;
		we      = 1'b0;
		m       = match_q && (c == kw_char(pos_q));
		p       = pos_q + 3'd1;
		push.valid   = 1'b0;
		push.job.len = len_q;
		push.job.ovf = ovf_q;

		case (mode_q)
			M_KEYWORD: begin
				if (p >= KW_TAIL_LEN) begin
					mode_d  = m ? M_OPENER : M_LINE;
					pos_d   = 3'd0;
					match_d = 1'b1;
				end else begin
					pos_d   = p;
					match_d = m;
				end
			end
			M_NAME: begin
				if (closer) begin
					push.valid = 1'b1;
					mode_d     = M_LINE;
				end else if (eol) begin
					mode_d = M_LINE;
				end else if (len_q < LEN_W'(NAME_DEPTH)) begin
					we    = 1'b1;
					len_d = len_q + LEN_W'(1);
				end else begin
					ovf_d = 1'b1;
				end
			end
			default: begin
				if (!blank) begin
					case (mode_q)
						M_HASH: begin
							if (c == CH_I) begin
								mode_d  = M_KEYWORD;
								pos_d   = 3'd0;
								match_d = 1'b1;
							end else begin
								mode_d = M_LINE;
							end
						end
						M_OPENER: begin
							if ((c == CH_LT) || (c == CH_QUOTE)) begin
								quote_d = (c == CH_QUOTE);
								len_d   = '0;
								ovf_d   = 1'b0;
								mode_d  = M_NAME;
							end else begin
								mode_d = M_LINE;
							end
						end
						M_SLASH: begin
							if (c == CH_SLASH) begin
								mode_d = M_LINE;
							end else if (c == CH_STAR) begin
								mode_d = M_BLOCK;
							end else begin
								mode_d = M_IDLE;
							end
						end
						M_LINE: begin
							if (eol) begin
								mode_d = M_IDLE;
							end
						end
						M_BLOCK: begin
							if (c == CH_STAR) begin
								mode_d = M_STAR;
							end
						end
						M_STAR: begin
							if (c == CH_SLASH) begin
								mode_d = M_IDLE;
							end else if (c != CH_STAR) begin
								mode_d = M_BLOCK;
							end
						end
						default: begin
							if (c == CH_HASH) begin
								mode_d = M_HASH;
							end else if (c == CH_SLASH) begin
								mode_d = M_SLASH;
							end else begin
								mode_d = M_IDLE;
							end
						end
					endcase
				end
			end
		endcase

		if (bytes.data.end_of_buffer) begin
			mode_d  = M_IDLE;
			pos_d   = 3'd0;
			match_d = 1'b1;
			quote_d = 1'b0;
			len_d   = '0;
			ovf_d   = 1'b0;
		end

		if (!accept) begin
			push.valid = 1'b0;
			we         = 1'b0;
		end
	end

	assign ram_we    = we;
	assign ram_waddr = len_q[AW-1:0];
	assign ram_wdata = c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			pos_q   <= 3'd0;
			match_q <= 1'b1;
			quote_q <= 1'b0;
			len_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			match_q <= match_d;
			quote_q <= quote_d;
			len_q   <= len_d;
			ovf_q   <= ovf_d;
		end
	end
endmodule

[rtl/core/isc_queue.sv]
// Two-entry job queue between front and back end.
// Depends on isc_pkg for job_t.
module isc_queue
	import isc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  job_push_t push,
	output logic      in_ready,
	input  logic      pop,
	output logic      out_valid,
	output job_t      out_job
);
	job_t       slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_job   = slot_q[rd_q];
	assign do_push   = push.valid && in_ready;
	assign do_pop    = pop && out_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

[rtl/core/isc_back.sv]
// Back end: takes queued jobs, reads the name RAM and sends one item per name byte
// (one empty item for an empty name) via an output register. Needs isc_pkg, isc_chan_if.
module isc_back
	import isc_pkg::*;
#(
	parameter int NAME_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_valid,
	input  job_t                          job,
	output logic                          job_pop,
	output logic                          ram_re,
	output logic [$clog2(NAME_DEPTH)-1:0] ram_raddr,
	input  logic [7:0]                    ram_rdata,
	output logic                          busy,
	isc_chan_if.source                    names
);
	localparam int AW = $clog2(NAME_DEPTH);

	logic             active_q, pend_q, pend_last_q, ovf_q;
	logic [LEN_W-1:0] len_q, idx_q;
	logic             out_valid_q;
	out_item_t        out_q;
	logic             out_free, issue, load_empty, last_rd;

	assign out_free   = !out_valid_q || names.ready;
	assign job_pop    = !active_q && !pend_q && job_valid;
	assign load_empty = active_q && (len_q == '0) && out_free;
	assign issue      = active_q && (len_q != '0) && !pend_q && out_free;
	assign last_rd    = (idx_q + LEN_W'(1)) == len_q;

	assign ram_re    = issue;
	assign ram_raddr = idx_q[AW-1:0];
	assign busy      = active_q || pend_q || job_valid;

	assign names.valid = out_valid_q;
	assign names.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (job_pop) begin
				active_q <= 1'b1;
			end else if (load_empty || (issue && last_rd)) begin
				active_q <= 1'b0;
			end
			pend_q <= issue;
			if (load_empty || pend_q) begin
				out_valid_q <= 1'b1;
			end else if (names.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			len_q <= job.len;
			ovf_q <= job.ovf;
			idx_q <= '0;
		end else if (issue) begin
			idx_q <= idx_q + LEN_W'(1);
		end
		if (issue) begin
			pend_last_q <= last_rd;
		end
		// out register is always empty when read data lands
		if (pend_q) begin
			out_q.name_byte      <= ram_rdata;
			out_q.name_empty     <= 1'b0;
			out_q.name_last      <= pend_last_q;
			out_q.name_truncated <= ovf_q;
		end else if (load_empty) begin
			out_q.name_byte      <= 8'h00;
			out_q.name_empty     <= 1'b1;
			out_q.name_last      <= 1'b1;
			out_q.name_truncated <= 1'b0;
		end
	end
endmodule

[rtl/core/include_directive_scanner_core.sv]
// Top level of the include directive scanner: front end, job queue, name RAM
// and back end. Depends on isc_pkg, isc_chan_if, isc_ram, isc_front, isc_queue, isc_back.
//
//  channel | role   | payload
//  --------+--------+-------------------------------------------------------
//  bytes   | sink   | text_byte[7:0], end_of_buffer
//  names   | source | name_byte[7:0], name_empty, name_last, name_truncated
//
// One source byte per cycle while no name is being collected.
// A name byte inside <...> or "..." waits until the back end has read the
// previous name out of the RAM; the back end moves each byte from a RAM read
// into the output register before it reads the next byte.
// Reset (arst_n low) returns the scanner to default scanning; the name RAM
// needs no clearing. Either side may stall at any time.
module include_directive_scanner_core
	import isc_pkg::*;
#(
	parameter int NAME_DEPTH = 64
) (
	input logic        clk,
	input logic        arst_n,
	isc_chan_if.sink   bytes,
	isc_chan_if.source names
);
	localparam int AW = $clog2(NAME_DEPTH);

	job_push_t       push;
	job_t            q_job;
	logic            q_ready, q_valid, q_pop, back_busy;
	logic            ram_we, ram_re;
	logic [AW-1:0]   ram_waddr, ram_raddr;
	logic [7:0]      ram_wdata, ram_rdata;

	isc_front #(.NAME_DEPTH(NAME_DEPTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.bytes       (bytes),
		.queue_ready (q_ready),
		.back_busy   (back_busy),
		.push        (push),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata)
	);

	isc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.in_ready  (q_ready),
		.pop       (q_pop),
		.out_valid (q_valid),
		.out_job   (q_job)
	);

	isc_ram #(.WIDTH(8), .DEPTH(NAME_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	isc_back #(.NAME_DEPTH(NAME_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job       (q_job),
		.job_pop   (q_pop),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.busy      (back_busy),
		.names     (names)
	);

`ifndef ASSERT_OFF
	// a finished name is only pushed while the back end is idle
	a_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> (!back_busy && q_ready))
		else $error("name job pushed while back end busy");

	// the name RAM is never overwritten under a name still being sent
	a_ram_owner: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !back_busy)
		else $error("name RAM written while back end reads it");

	// front and back never touch the RAM in the same cycle
	a_ram_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("name RAM read and written together");

	// an empty name is always a one-item name
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(names.valid && names.data.name_empty) |-> names.data.name_last)
		else $error("empty name item without last mark");
`endif
endmodule

[verif/include_directive_scanner_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for include_directive_scanner_core: C-like source bytes in,
// include file names out, checked item by item against a behavioral scanner model.
// Depends on isc_pkg, isc_chan_if and the scanner RTL.
module include_directive_scanner_core_tb;
	import isc_pkg::*;

	localparam int NAME_DEPTH   = 64;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int TAIL_CYCLES  = 300;
	localparam int SOURCE_BYTES = 310;
	localparam int SHOW_MAX     = 10;
	localparam logic [47:0] KW_TAIL = "nclude";

	// ways a directive can be spoiled
	typedef enum int {
		FL_NONE,
		FL_HASH,
		FL_KEYWORD,
		FL_OPENER,
		FL_EOL_IN_NAME,
		FL_EOB_CUT
	} flaw_t;

	logic clk;
	logic arst_n;

	isc_chan_if #(.T(in_item_t))  bytes_if ();
	isc_chan_if #(.T(out_item_t)) names_if ();

	include_directive_scanner_core #(.NAME_DEPTH(NAME_DEPTH)) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.bytes (bytes_if),
		.names (names_if)
	);

	// scanner model state
	scan_mode_t       sc_mode     = M_IDLE;
	logic [2:0]       kw_pos      = 3'd0;
	logic             kw_ok       = 1'b1;
	logic             quote_close = 1'b0;
	logic [7:0]       name_buf [NAME_DEPTH];
	logic [LEN_W-1:0] name_len    = '0;
	logic             name_ovf    = 1'b0;

	in_item_t  pending_bytes [$];
	out_item_t expected_names [$];

	bit byte_taken, name_taken;
	bit src_calm, sink_calm;
	int src_gap, sink_wait;
	int cycle_count, bytes_sent, buffer_ends, names_seen, truncated_seen;
	int items_checked, mismatches;

	function automatic void queue_name();
		out_item_t r;
		if (name_len == 0) begin
			r = '{name_byte: 8'h00, name_empty: 1'b1, name_last: 1'b1,
			      name_truncated: 1'b0};
			expected_names.push_back(r);
		end else begin
			for (int k = 0; k < name_len; k++) begin
				r.name_byte      = name_buf[k];
				r.name_empty     = 1'b0;
				r.name_last      = (k == name_len - 1);
				r.name_truncated = name_ovf;
				expected_names.push_back(r);
			end
		end
	endfunction

	// advance the scanner by one source byte, queueing any finished name
	function automatic void scan_byte(in_item_t it);
		logic [7:0] c;
		logic       blank;
		logic       eol;
		c     = it.text_byte;
		blank = (c == CH_SP) || (c == CH_TAB);
		eol   = (c == CH_LF) || (c == CH_CR);
		case (sc_mode)
		M_KEYWORD: begin
			// raw compare, blanks included
			if (kw_pos < KW_TAIL_LEN && c != KW_TAIL[47 - 8 * int'(kw_pos) -: 8])
				kw_ok = 1'b0;
			kw_pos = kw_pos + 3'd1;
			if (kw_pos >= KW_TAIL_LEN) begin
				sc_mode = kw_ok ? M_OPENER : M_LINE;
				kw_pos  = 3'd0;
				kw_ok   = 1'b1;
			end
		end
		M_NAME: begin
			if (c == (quote_close ? CH_QUOTE : CH_GT)) begin
				queue_name();
				sc_mode = M_LINE;
			end else if (eol) begin
				sc_mode = M_LINE;
			end else if (name_len < NAME_DEPTH) begin
				name_buf[name_len] = c;
				name_len = name_len + 1'b1;
			end else begin
				name_ovf = 1'b1;
			end
		end
		default: begin
			if (!blank) begin
				case (sc_mode)
				M_HASH: begin
					if (c == CH_I) begin
						sc_mode = M_KEYWORD;
						kw_pos  = 3'd0;
						kw_ok   = 1'b1;
					end else begin
						sc_mode = M_LINE;
					end
				end
				M_OPENER: begin
					if (c == CH_LT || c == CH_QUOTE) begin
						quote_close = (c == CH_QUOTE);
						name_len    = '0;
						name_ovf    = 1'b0;
						sc_mode     = M_NAME;
					end else begin
						sc_mode = M_LINE;
					end
				end
				M_SLASH: begin
					if (c == CH_SLASH)
						sc_mode = M_LINE;
					else if (c == CH_STAR)
						sc_mode = M_BLOCK;
					else
						sc_mode = M_IDLE;
				end
				M_LINE: begin
					if (eol)
						sc_mode = M_IDLE;
				end
				M_BLOCK: begin
					if (c == CH_STAR)
						sc_mode = M_STAR;
				end
				M_STAR: begin
					if (c == CH_SLASH)
						sc_mode = M_IDLE;
					else if (c != CH_STAR)
						sc_mode = M_BLOCK;
				end
				default: begin
					if (c == CH_HASH)
						sc_mode = M_HASH;
					else if (c == CH_SLASH)
						sc_mode = M_SLASH;
					else
						sc_mode = M_IDLE;
				end
				endcase
			end
		end
		endcase
		if (it.end_of_buffer) begin
			sc_mode     = M_IDLE;
			kw_pos      = 3'd0;
			kw_ok       = 1'b1;
			quote_close = 1'b0;
			name_len    = '0;
			name_ovf    = 1'b0;
		end
	endfunction

	function automatic void note_mismatch(string what, out_item_t want, out_item_t got);
		mismatches++;
		if (mismatches <= SHOW_MAX)
			$display({"[%0d] %s: expected byte %02h empty %b last %b trunc %b, ",
				"got byte %02h empty %b last %b trunc %b"},
				cycle_count, what, want.name_byte, want.name_empty, want.name_last,
				want.name_truncated, got.name_byte, got.name_empty, got.name_last,
				got.name_truncated);
	endfunction

	function automatic void check_name(out_item_t got);
		out_item_t want;
		if (expected_names.size() == 0) begin
			note_mismatch("name item with none expected", 'x, got);
			return;
		end
		want = expected_names.pop_front();
		items_checked++;
		if (want.name_last)
			names_seen++;
		if (want.name_last && want.name_truncated)
			truncated_seen++;
		// name byte carries nothing on an empty name
		if ((!want.name_empty && got.name_byte !== want.name_byte) ||
		    got.name_empty !== want.name_empty || got.name_last !== want.name_last ||
		    got.name_truncated !== want.name_truncated)
			note_mismatch("name item mismatch", want, got);
	endfunction

	// ---------------- stimulus builders ----------------

	function automatic void push_byte(logic [7:0] c, logic eob = 1'b0);
		in_item_t it;
		it.text_byte     = c;
		it.end_of_buffer = eob;
		pending_bytes.push_back(it);
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endfunction

	function automatic void push_blanks();
		int n;
		n = $urandom_range(0, 2);
		repeat (n)
			push_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
	endfunction

	function automatic void push_eol();
		push_byte(($urandom_range(0, 3) == 0) ? CH_CR : CH_LF);
	endfunction

	function automatic void mark_buffer_end();
		in_item_t it;
		it = pending_bytes.pop_back();
		it.end_of_buffer = 1'b1;
		pending_bytes.push_back(it);
	endfunction

	function automatic logic [7:0] name_char(logic [7:0] closer);
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (c == closer || c == CH_LF || c == CH_CR)
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	function automatic int name_size();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(7, NAME_DEPTH + 4);
		return $urandom_range(0, 6);
	endfunction

	function automatic void gen_directive(int nlen, flaw_t flaw);
		logic       quoted;
		logic [7:0] closer;
		logic [7:0] c;
		int         cut_at;
		int         bad_pos;
		quoted  = 1'($urandom_range(0, 1));
		closer  = quoted ? CH_QUOTE : CH_GT;
		bad_pos = $urandom_range(0, 5);
		if ((flaw == FL_EOL_IN_NAME || flaw == FL_EOB_CUT) && nlen == 0)
			nlen = 1;
		cut_at = (nlen > 0) ? $urandom_range(0, nlen - 1) : 0;
		push_blanks();
		push_byte(CH_HASH);
		push_blanks();
		if (flaw == FL_HASH) begin
			c = 8'($urandom_range(0, 255));
			if (c == CH_I || c == CH_SP || c == CH_TAB)
				c = CH_LF;
			push_byte(c);
		end else begin
			push_byte(CH_I);
		end
		for (int p = 0; p < 6; p++) begin
			c = KW_TAIL[47 - 8 * p -: 8];
			if (flaw == FL_KEYWORD && p == bad_pos)
				c = c ^ (8'h01 << $urandom_range(0, 7));
			push_byte(c);
		end
		push_blanks();
		if (flaw == FL_OPENER) begin
			c = 8'($urandom_range(0, 255));
			if (c == CH_LT || c == CH_QUOTE || c == CH_SP || c == CH_TAB)
				c = 8'h78;
			push_byte(c);
		end
		push_byte(quoted ? CH_QUOTE : CH_LT);
		for (int k = 0; k < nlen; k++) begin
			if (flaw == FL_EOL_IN_NAME && k == cut_at)
				push_eol();
			if (flaw == FL_EOB_CUT && k == cut_at) begin
				push_byte(name_char(closer), 1'b1);
				return;
			end
			push_byte(name_char(closer));
		end
		push_byte(closer);
		repeat ($urandom_range(0, 3))
			push_byte(8'($urandom_range(0, 255)));
		push_eol();
	endfunction

	function automatic void gen_comment();
		int         kind;
		logic [7:0] c;
		kind = $urandom_range(0, 2);
		push_blanks();
		push_byte(CH_SLASH);
		if (kind == 0) begin
			push_byte(CH_SLASH);
			if ($urandom_range(0, 1))
				push_text("#include<x>");
			repeat ($urandom_range(0, 5))
				push_byte(name_char(CH_LF));
			push_eol();
		end else if (kind == 1) begin
			push_byte(CH_STAR);
			repeat ($urandom_range(0, 6))
				push_byte(($urandom_range(0, 3) == 0) ? CH_STAR
				          : 8'($urandom_range(0, 255)));
			push_byte(CH_STAR);
			push_byte(CH_SLASH);
		end else begin
			// lone slash eats the next non-blank byte after it
			c = 8'($urandom_range(0, 255));
			if (c == CH_SLASH || c == CH_STAR)
				c = CH_HASH;
			push_byte(c);
		end
	endfunction

	function automatic void gen_noise();
		logic [7:0] hot [10] = '{CH_HASH, CH_SLASH, CH_STAR, CH_LT, CH_GT, CH_QUOTE,
		                         CH_LF, CH_CR, CH_SP, CH_I};
		repeat ($urandom_range(1, 8)) begin
			if ($urandom_range(0, 3) == 0)
				push_byte(hot[$urandom_range(0, 9)]);
			else
				push_byte(8'($urandom_range(0, 255)));
		end
	endfunction

	// ---------------- clock, driver, monitor ----------------

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!bytes_if.valid || byte_taken) begin
				if (src_gap > 0) begin
					bytes_if.valid <= 1'b0;
					src_gap--;
				end else if (pending_bytes.size() > 0) begin
					bytes_if.data  <= pending_bytes.pop_front();
					bytes_if.valid <= 1'b1;
					if ($urandom_range(0, 39) == 0)
						src_calm = !src_calm;
					src_gap = src_calm ? 0 : $urandom_range(0, 4);
				end else begin
					bytes_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (name_taken) begin
				if ($urandom_range(0, 39) == 0)
					sink_calm = !sink_calm;
				sink_wait = sink_calm ? 0 : $urandom_range(0, 4);
			end
			if (sink_wait > 0) begin
				names_if.ready <= 1'b0;
				sink_wait--;
			end else begin
				names_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d name items outstanding",
				cycle_count, expected_names.size());
			$display("*** FAILED ***");
			$finish;
		end else begin
			byte_taken = bytes_if.valid && bytes_if.ready;
			name_taken = names_if.valid && names_if.ready;
			if (byte_taken) begin
				bytes_sent++;
				if (bytes_if.data.end_of_buffer)
					buffer_ends++;
				scan_byte(bytes_if.data);
			end
			if (name_taken)
				check_name(names_if.data);
		end
	end

	initial begin
		int pick;
		bytes_if.valid = 1'b0;
		bytes_if.data  = '0;
		names_if.ready = 1'b0;
		arst_n         = 1'b0;

		// directed: extreme name bytes, lone slash before an empty quoted name
		push_text("#include<");
		push_byte(8'hFF);
		push_byte(8'h00);
		push_byte(CH_GT);
		push_byte(CH_LF);
		push_text("/x#include\"\"");
		push_byte(CH_LF, 1'b1);

		// names that exactly fill and overflow the buffer
		gen_directive(NAME_DEPTH, FL_NONE);
		gen_directive(NAME_DEPTH + 3, FL_NONE);

		while (pending_bytes.size() < SOURCE_BYTES) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				gen_directive(name_size(), FL_NONE);
			else if (pick < 65)
				gen_directive(name_size(), flaw_t'($urandom_range(1, 5)));
			else if (pick < 85)
				gen_comment();
			else
				gen_noise();
			if ($urandom_range(0, 11) == 0)
				mark_buffer_end();
		end

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() != 0 || bytes_if.valid)
			@(negedge clk);
		while (expected_names.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("scanned %0d source bytes across %0d buffer ends in %0d cycles",
			bytes_sent, buffer_ends, cycle_count);
		$display("checked %0d name items: %0d names, %0d truncated; %0d mismatches",
			items_checked, names_seen, truncated_seen, mismatches);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
